// ===== hdl/ttfs_pkg.sv =====
// Shared types, constants and the tile transpose function for the tile transpose frame store.
package ttfs_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TileRows = 8;
  localparam int unsigned RowSelW  = 3;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ColW     = 5;
  localparam int unsigned RowW     = 5;
  localparam int unsigned DataW    = 64;
  localparam int unsigned InTdataW = 80;

  localparam logic [ByteW-1:0] InvertMask = 8'hFF;

  typedef enum logic [CmdW-1:0] {
    CmdWrite  = 2'd0,
    CmdRead   = 2'd1,
    CmdRewind = 2'd2
  } cmd_e;

  typedef logic [ByteW-1:0] byte_t;

  // Row r of a tile: bit (7-k) takes bit r of column byte k.
  function automatic byte_t tile_row_byte(input logic [DataW-1:0] data,
                                          input logic [RowSelW-1:0] r);
    byte_t v;
    v = '0;
    for (int k = 0; k < TileRows; k++) begin
      v[ByteW-1-k] = data[ByteW*k + int'(r)];
    end
    return v;
  endfunction

endpackage

// ===== hdl/ttfs_bank.sv =====
// One row-in-tile bank of the frame store: one write port, one registered read port.
module ttfs_bank #(
  parameter int unsigned Depth = 361,
  parameter int unsigned Aw    = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [Aw-1:0]            waddr_i,
  input  logic [ttfs_pkg::ByteW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [Aw-1:0]            raddr_i,
  output logic [ttfs_pkg::ByteW-1:0] rdata_o
);

  logic [ttfs_pkg::ByteW-1:0] mem_q [Depth];
  logic [ttfs_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ttfs_wr_dec.sv =====
// Write decode: range check, bank address and bit transpose of one tile.
module ttfs_wr_dec #(
  parameter int unsigned TilesAcross = 19,
  parameter int unsigned TilesDown   = 19,
  parameter int unsigned Aw          = 9
) (
  input  logic                       wr_i,
  input  logic [ttfs_pkg::ColW-1:0]  col_i,
  input  logic [ttfs_pkg::RowW-1:0]  row_i,
  input  logic [ttfs_pkg::DataW-1:0] data_i,
  output logic                       we_o,
  output logic [Aw-1:0]              addr_o,
  output ttfs_pkg::byte_t            rows_o [ttfs_pkg::TileRows]
);

  localparam int unsigned ProdW = Aw + 7;

  logic [ProdW-1:0] addr_full;

  // Drop tiles that fall off the frame.
  assign we_o = wr_i && (int'(col_i) < TilesAcross) && (int'(row_i) < TilesDown);

  assign addr_full = ProdW'(row_i) * ProdW'(TilesAcross) + ProdW'(col_i);
  assign addr_o    = addr_full[Aw-1:0];

  always_comb begin
    for (int r = 0; r < ttfs_pkg::TileRows; r++) begin
      rows_o[r] = ttfs_pkg::tile_row_byte(data_i, ttfs_pkg::RowSelW'(r));
    end
  end

endmodule

// ===== hdl/ttfs_rd_ptr.sv =====
// Read pointer kept as bank select, bank address and column, stepped in raster order.
module ttfs_rd_ptr #(
  parameter int unsigned TilesAcross = 19,
  parameter int unsigned TilesDown   = 19,
  parameter int unsigned Aw          = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         rewind_i,
  output logic [ttfs_pkg::RowSelW-1:0] bank_o,
  output logic [Aw-1:0]                addr_o,
  output logic                         last_o
);

  localparam int unsigned TileCount = TilesAcross * TilesDown;
  localparam int unsigned ColCntW   = (TilesAcross > 1) ? $clog2(TilesAcross) : 1;

  logic [ttfs_pkg::RowSelW-1:0] bank_q, bank_d;
  logic [Aw-1:0]                addr_q, addr_d;
  logic [ColCntW-1:0]           col_q, col_d;
  logic                         last;
  logic                         col_wrap;

  assign last = (bank_q == ttfs_pkg::RowSelW'(ttfs_pkg::TileRows - 1)) &&
                (addr_q == Aw'(TileCount - 1));
  assign col_wrap = (col_q == ColCntW'(TilesAcross - 1));

  always_comb begin
    bank_d = bank_q;
    addr_d = addr_q;
    col_d  = col_q;
    if (rewind_i || (adv_i && last)) begin
      bank_d = '0;
      addr_d = '0;
      col_d  = '0;
    end else if (adv_i) begin
      if (!col_wrap) begin
        col_d  = col_q + 1'b1;
        addr_d = addr_q + 1'b1;
      end else if (bank_q == ttfs_pkg::RowSelW'(ttfs_pkg::TileRows - 1)) begin
        // Next tile row starts right after the last tile of this one.
        col_d  = '0;
        bank_d = '0;
        addr_d = addr_q + 1'b1;
      end else begin
        // Next pixel row in the same tile row: back to its first tile.
        col_d  = '0;
        bank_d = bank_q + 1'b1;
        addr_d = addr_q - Aw'(TilesAcross - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
      addr_q <= '0;
      col_q  <= '0;
    end else begin
      bank_q <= bank_d;
      addr_q <= addr_d;
      col_q  <= col_d;
    end
  end

  assign bank_o = bank_q;
  assign addr_o = addr_q;
  assign last_o = last;

endmodule

// ===== hdl/tile_transpose_frame_store.sv =====
// Top level of the tile transpose frame store: command decode, banked store, read pipeline.
//
// Usage:
//   Slave stream carries commands. tuser holds the command (write tile, read next byte,
//   rewind read pointer); tdata holds tile_column, tile_row and the 64-bit tile.
//   A write tile word bit-transposes the 8x8 tile and stores its eight row bytes together,
//   one per bank; tiles off the frame are dropped. A rewind word resets the read pointer.
//   Neither gives an output word.
//   A read word returns the next frame byte, inverted, on the master stream; tlast marks
//   the final byte of the frame, after which the pointer wraps to the first byte.
// Throughput and pipeline:
//   One command word per cycle while the master stream keeps taking its words. A read
//   word's result passes the registered read port of the frame store and then the
//   output register before it shows on the master stream.
//   The frame store is eight banks, one per pixel row of a tile, each TILES_ACROSS *
//   TILES_DOWN bytes deep, so all eight row bytes of a tile are written together.
// Reset:
//   Clears the read pointer and the pipeline valids. Store contents are undefined until
//   written; no clearing pass runs.
// Stall:
//   While the output word waits, one read stays held in the bank read stage; tready drops
//   only when both are full and the receiver holds tready low.
module tile_transpose_frame_store #(
  parameter int unsigned TILES_ACROSS = 19,
  parameter int unsigned TILES_DOWN   = 19
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ttfs_pkg::InTdataW-1:0]   s_axis_tdata,  // tile_column[4:0], tile_row[9:5],
                                                         // tile_data[73:10], zero[79:74]
  input  logic [ttfs_pkg::CmdW-1:0]       s_axis_tuser,  // command[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ttfs_pkg::ByteW-1:0]      m_axis_tdata,  // pixel_byte[7:0]
  output logic                            m_axis_tlast   // last_byte
);

  localparam int unsigned TileCount = TILES_ACROSS * TILES_DOWN;
  localparam int unsigned BankAw    = (TileCount > 1) ? $clog2(TileCount) : 1;

  // Payload fields
  logic [ttfs_pkg::ColW-1:0]  in_col;
  logic [ttfs_pkg::RowW-1:0]  in_row;
  logic [ttfs_pkg::DataW-1:0] in_data;

  assign in_col  = s_axis_tdata[ttfs_pkg::ColW-1:0];
  assign in_row  = s_axis_tdata[ttfs_pkg::ColW +: ttfs_pkg::RowW];
  assign in_data = s_axis_tdata[ttfs_pkg::ColW + ttfs_pkg::RowW +: ttfs_pkg::DataW];

  // Command decode on the accepted word
  logic in_acc;
  logic wr_acc, rd_acc, rw_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wr_acc = 1'b0;
    rd_acc = 1'b0;
    rw_acc = 1'b0;
    case (ttfs_pkg::cmd_e'(s_axis_tuser))
      ttfs_pkg::CmdWrite:  wr_acc = in_acc;
      ttfs_pkg::CmdRead:   rd_acc = in_acc;
      ttfs_pkg::CmdRewind: rw_acc = in_acc;
      default: begin
        // unused command: drop
      end
    endcase
  end

  // Write path: transpose and bank address
  logic                we;
  logic [BankAw-1:0]   waddr;
  ttfs_pkg::byte_t     wrows [ttfs_pkg::TileRows];

  ttfs_wr_dec #(
    .TilesAcross (TILES_ACROSS),
    .TilesDown   (TILES_DOWN),
    .Aw          (BankAw)
  ) u_wr_dec (
    .wr_i   (wr_acc),
    .col_i  (in_col),
    .row_i  (in_row),
    .data_i (in_data),
    .we_o   (we),
    .addr_o (waddr),
    .rows_o (wrows)
  );

  // Read pointer
  logic [ttfs_pkg::RowSelW-1:0] rd_bank;
  logic [BankAw-1:0]            rd_addr;
  logic                         rd_last;

  ttfs_rd_ptr #(
    .TilesAcross (TILES_ACROSS),
    .TilesDown   (TILES_DOWN),
    .Aw          (BankAw)
  ) u_rd_ptr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (rd_acc),
    .rewind_i (rw_acc),
    .bank_o   (rd_bank),
    .addr_o   (rd_addr),
    .last_o   (rd_last)
  );

  // Frame store banks: every bank reads on a read word, the selected one is used
  ttfs_pkg::byte_t bank_rdata [ttfs_pkg::TileRows];

  for (genvar b = 0; b < ttfs_pkg::TileRows; b++) begin : g_bank
    ttfs_bank #(
      .Depth (TileCount),
      .Aw    (BankAw)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wrows[b]),
      .re_i    (rd_acc),
      .raddr_i (rd_addr),
      .rdata_o (bank_rdata[b])
    );
  end

  // Bank read stage and output register
  logic                         s1_valid_q, s1_valid_d;
  logic [ttfs_pkg::RowSelW-1:0] s1_bank_q;
  logic                         s1_last_q;
  logic                         s1_adv;
  logic                         out_valid_q, out_valid_d;
  ttfs_pkg::byte_t              out_byte_q;
  logic                         out_last_q;

  // Advance the read stage whenever the output register is free or being emptied.
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  assign s1_valid_d  = rd_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      s1_bank_q <= rd_bank;
      s1_last_q <= rd_last;
    end
    if (s1_adv && s1_valid_q) begin
      out_byte_q <= bank_rdata[s1_bank_q] ^ ttfs_pkg::InvertMask;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/ttfs_checker.sv =====
// Port-level checker for the tile transpose frame store, bound to the top level.
module ttfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [ttfs_pkg::CmdW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ttfs_pkg::ByteW-1:0]    m_axis_tdata,
  input logic                          m_axis_tlast
);

  logic rd_acc;
  assign rd_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ttfs_pkg::CmdRead);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Back-pressure only when the output word is stalled.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // An output word that appears on an idle output comes from a read that went straight through the bank read stage.
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rd_acc, 2))
    else $error("output word without a matching read");

  // A frame holds at least eight bytes, so the word after the last is never last.
  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !(m_axis_tvalid && m_axis_tlast))
    else $error("two last bytes in a row");

endmodule

bind tile_transpose_frame_store ttfs_checker u_ttfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
